FILE: src/model_transform_matrix_engine_defines.svh
// Assertion macros for the matrix engine. They expect clk and arst_n in scope.
`ifndef MODEL_TRANSFORM_MATRIX_ENGINE_DEFINES_SVH
`define MODEL_TRANSFORM_MATRIX_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MTME_ASSERT_HOLDS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define MTME_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define MTME_ASSERT_HOLDS(lbl, cond)
`define MTME_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

FILE: src/mtme_pkg.sv
`default_nettype none
package mtme_pkg;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CW = 5;
	localparam logic [2:0] CMD_FILL = 3'd0;
	localparam logic [2:0] CMD_TRANS = 3'd1;
	localparam logic [2:0] CMD_ROTX = 3'd2;
	localparam logic [2:0] CMD_ROTY = 3'd3;
	localparam logic [2:0] CMD_ROTZ = 3'd4;
	localparam logic [2:0] CMD_SCALE = 3'd5;
	localparam logic signed [26:0] DEG360 = 27'sd23592960;
	localparam logic signed [26:0] DEG180 = 27'sd11796480;
	localparam logic signed [26:0] DEG90 = 27'sd5898240;
	localparam logic signed [26:0] WRAP_K = 27'sd524288;
	localparam logic signed [28:0] PI_Q32 = 29'sd74961321;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic start;
		logic round30;
	} mac_ctl_t;

	typedef struct packed {
		logic done;
		logic sat;
		logic [31:0] r1;
		logic [31:0] r2;
	} mac_res_t;

	typedef struct packed {
		logic done;
		logic signed [33:0] cosv;
		logic signed [33:0] sinv;
	} cor_res_t;

	function automatic logic signed [35:0] atan_q32(input logic [CW-1:0] i);
		case (i)
			5'd0: atan_q32 = 36'sd3373259426;
			5'd1: atan_q32 = 36'sd1991351318;
			5'd2: atan_q32 = 36'sd1052175346;
			5'd3: atan_q32 = 36'sd534100635;
			5'd4: atan_q32 = 36'sd268086748;
			5'd5: atan_q32 = 36'sd134174063;
			5'd6: atan_q32 = 36'sd67103403;
			5'd7: atan_q32 = 36'sd33553749;
			5'd8: atan_q32 = 36'sd16777131;
			5'd9: atan_q32 = 36'sd8388597;
			5'd10: atan_q32 = 36'sd4194303;
			default: atan_q32 = 36'sd1 <<< (6'd32 - {1'b0, i});
		endcase
	endfunction
endpackage
`default_nettype wire

FILE: src/model_transform_matrix_engine.sv
// Model transform matrix engine: holds a 4x4 Q16.16 matrix, updates it per command.
// Input stream: s_tuser carries the command code, s_tdata the operands. One command
// is taken at a time; s_tready is high only while the engine is idle.
// Output stream: after every command the four rows are sent as four transfers,
// row 0 first; m_tlast marks row 3, m_tuser carries the row index and the
// saturation flag of the command.
// Configuration: cfg_we writes cfg_wdata into the scale threshold at once.
// Sequence to the first row: fill, translate and unused codes go straight to the
// output; rotation runs the bit-serial angle reduction and CORDIC, then one pass
// of the bit-serial multiply unit per column; scale forms the combined factor in
// the multiply unit and, when applied, one more pass for each of three diagonal
// entries. A new command is taken only after its four row transfers.
// Reset clears the matrix to zero and sets the threshold to one.
// A stall on m_tready holds the current row and keeps s_tready low.
`default_nettype none
`include "model_transform_matrix_engine_defines.svh"
module model_transform_matrix_engine #(
	parameter int CORDIC_STEPS = mtme_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// offset_x, offset_y, offset_z, angle_deg, factor, fill_value
	input  wire logic [191:0] s_tdata,
	// cmd
	input  wire logic [2:0] s_tuser,
	output logic m_tvalid,
	input  wire logic m_tready,
	// entry_col0, entry_col1, entry_col2, entry_col3
	output logic [127:0] m_tdata,
	// row_index, saturated
	output logic [2:0] m_tuser,
	output logic m_tlast,
	input  wire logic cfg_we,
	input  wire logic [16:0] cfg_wdata
);
	import mtme_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_COR = 4'd1;
	localparam logic [3:0] ST_ROTL = 4'd2;
	localparam logic [3:0] ST_ROTW = 4'd3;
	localparam logic [3:0] ST_SCL = 4'd4;
	localparam logic [3:0] ST_SCW = 4'd5;
	localparam logic [3:0] ST_DGL = 4'd6;
	localparam logic [3:0] ST_DGW = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	logic [3:0] state_q;
	logic [31:0] m_q [4][4];
	logic [16:0] thr_q;
	logic [1:0] row_q, col_q, p_q, q_q;
	logic sat_q;
	logic [31:0] factor_q, prod_q;
	logic signed [33:0] cos_q, sin_q;

	mac_ctl_t mctl;
	mac_res_t mres;
	cor_res_t cres;
	logic s_acc, cor_start;
	logic signed [33:0] mul_c, mul_s;
	logic [31:0] word_p, word_q, mag;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign cor_start = s_acc && (s_tuser == CMD_ROTX || s_tuser == CMD_ROTY
		|| s_tuser == CMD_ROTZ);

	always_comb begin
		mctl.start = (state_q == ST_ROTL) || (state_q == ST_SCL) || (state_q == ST_DGL);
		mctl.round30 = (state_q == ST_ROTL);
		mul_c = 34'($signed(prod_q));
		mul_s = '0;
		word_p = m_q[col_q][col_q];
		word_q = '0;
		if (state_q == ST_ROTL) begin
			mul_c = cos_q;
			mul_s = sin_q;
			word_p = m_q[p_q][col_q];
			word_q = m_q[q_q][col_q];
		end else if (state_q == ST_SCL) begin
			mul_c = 34'($signed(factor_q));
			word_p = m_q[3][3];
		end
		mag = mres.r1[31] ? (~mres.r1 + 32'd1) : mres.r1;
	end

	mtme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.angle(s_tdata[127:96]),
		.res(cres)
	);

	mtme_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mctl),
		.mul_c(mul_c),
		.mul_s(mul_s),
		.word_p(word_p),
		.word_q(word_q),
		.res(mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q <= 17'd1;
			row_q <= '0;
			col_q <= '0;
			p_q <= '0;
			q_q <= '0;
			sat_q <= 1'b0;
			factor_q <= '0;
			prod_q <= '0;
			cos_q <= '0;
			sin_q <= '0;
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					m_q[r][c] <= '0;
		end else begin
			if (cfg_we)
				thr_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						sat_q <= 1'b0;
						row_q <= '0;
						col_q <= '0;
						state_q <= ST_EMIT;
						case (s_tuser)
							CMD_FILL: begin
								for (int r = 0; r < 4; r++)
									for (int c = 0; c < 4; c++)
										m_q[r][c] <= s_tdata[191:160];
							end
							CMD_TRANS: begin
								m_q[0][3] <= s_tdata[31:0];
								m_q[1][3] <= s_tdata[63:32];
								m_q[2][3] <= s_tdata[95:64];
							end
							CMD_ROTX: begin
								p_q <= 2'd1;
								q_q <= 2'd2;
								state_q <= ST_COR;
							end
							CMD_ROTY: begin
								p_q <= 2'd2;
								q_q <= 2'd0;
								state_q <= ST_COR;
							end
							CMD_ROTZ: begin
								p_q <= 2'd0;
								q_q <= 2'd1;
								state_q <= ST_COR;
							end
							CMD_SCALE: begin
								factor_q <= s_tdata[159:128];
								state_q <= ST_SCL;
							end
							default: ;
						endcase
					end
				end
				ST_COR: begin
					if (cres.done) begin
						cos_q <= cres.cosv;
						sin_q <= cres.sinv;
						state_q <= ST_ROTL;
					end
				end
				ST_ROTL: state_q <= ST_ROTW;
				ST_ROTW: begin
					if (mres.done) begin
						m_q[p_q][col_q] <= mres.r1;
						m_q[q_q][col_q] <= mres.r2;
						sat_q <= sat_q | mres.sat;
						col_q <= col_q + 1'b1;
						state_q <= (col_q == 2'd3) ? ST_EMIT : ST_ROTL;
					end
				end
				ST_SCL: state_q <= ST_SCW;
				ST_SCW: begin
					if (mres.done) begin
						sat_q <= sat_q | mres.sat;
						prod_q <= mres.r1;
						col_q <= '0;
						state_q <= (mag >= 32'(thr_q)) ? ST_DGL : ST_EMIT;
					end
				end
				ST_DGL: state_q <= ST_DGW;
				ST_DGW: begin
					if (mres.done) begin
						m_q[col_q][col_q] <= mres.r1;
						sat_q <= sat_q | mres.sat;
						col_q <= col_q + 1'b1;
						if (col_q == 2'd2) begin
							m_q[3][3] <= prod_q;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DGL;
						end
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						row_q <= row_q + 1'b1;
						if (row_q == 2'd3)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata = {m_q[row_q][3], m_q[row_q][2], m_q[row_q][1], m_q[row_q][0]};
	assign m_tuser = {sat_q, row_q};
	assign m_tlast = (row_q == 2'd3);

	`MTME_ASSERT_IMPLIES(a_one_at_a_time, s_tready, !m_tvalid)
	`MTME_ASSERT_IMPLIES(a_cordic_done_waited, cres.done, state_q == ST_COR)
	`MTME_ASSERT_IMPLIES(a_mac_done_waited, mres.done,
		state_q == ST_ROTW || state_q == ST_SCW || state_q == ST_DGW)
	`MTME_ASSERT_HOLDS(a_last_row_closes, !(m_tvalid && m_tready && m_tlast) ||
		(row_q == 2'd3))
endmodule
`default_nettype wire

FILE: src/mtme_cordic.sv
`default_nettype none
module mtme_cordic #(
	parameter int CORDIC_STEPS = mtme_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [31:0] angle,
	output mtme_pkg::cor_res_t res
);
	import mtme_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_MOD = 3'd1;
	localparam logic [2:0] PH_FOLD = 3'd2;
	localparam logic [2:0] PH_RAD = 3'd3;
	localparam logic [2:0] PH_ITER = 3'd4;

	logic [2:0] ph_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] src_q;
	logic [24:0] rem_q;
	logic signed [26:0] r_q;
	logic neg_q;
	logic signed [35:0] z_q;
	logic signed [33:0] x_q, y_q;
	logic done_q;

	logic [25:0] t_rem;
	logic signed [26:0] r0, r1, rf;
	logic nf;
	logic signed [55:0] rad;
	logic signed [33:0] dx, dy;
	logic signed [35:0] at;

	always_comb begin
		t_rem = {rem_q, src_q[31]};
		if (t_rem >= 26'(DEG360))
			t_rem = t_rem - 26'(DEG360);
		r0 = $signed({2'b00, rem_q}) - WRAP_K;
		if (r0 < 0)
			r0 = r0 + DEG360;
		r1 = (r0 >= DEG180) ? r0 - DEG360 : r0;
		rf = r1;
		nf = 1'b0;
		if (r1 > DEG90) begin
			rf = DEG180 - r1;
			nf = 1'b1;
		end else if (r1 < -DEG90) begin
			rf = -DEG180 - r1;
			nf = 1'b1;
		end
		rad = 56'(r_q) * 56'(PI_Q32);
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		at = atan_q32(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						ph_q <= PH_MOD;
						cnt_q <= '0;
					end
				end
				PH_MOD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(31))
						ph_q <= PH_FOLD;
				end
				PH_FOLD: ph_q <= PH_RAD;
				PH_RAD: begin
					ph_q <= PH_ITER;
					cnt_q <= '0;
				end
				PH_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
						ph_q <= PH_IDLE;
						done_q <= 1'b1;
					end
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			PH_IDLE: begin
				src_q <= angle ^ 32'h8000_0000;
				rem_q <= '0;
			end
			PH_MOD: begin
				rem_q <= t_rem[24:0];
				src_q <= {src_q[30:0], 1'b0};
			end
			PH_FOLD: begin
				r_q <= rf;
				neg_q <= nf;
			end
			PH_RAD: begin
				z_q <= 36'(rad >>> 16);
				x_q <= GAIN_Q30;
				y_q <= '0;
			end
			PH_ITER: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.cosv = neg_q ? -x_q : x_q;
	assign res.sinv = y_q;
endmodule
`default_nettype wire

FILE: src/mtme_mac.sv
`default_nettype none
module mtme_mac (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mtme_pkg::mac_ctl_t ctl,
	input  wire logic signed [33:0] mul_c,
	input  wire logic signed [33:0] mul_s,
	input  wire logic [31:0] word_p,
	input  wire logic [31:0] word_q,
	output mtme_pkg::mac_res_t res
);
	import mtme_pkg::*;

	logic busy_q, fin_q, done_q, r30_q;
	logic [CW-1:0] cnt_q;
	logic signed [33:0] c_q, s_q;
	logic [31:0] sp_q, sq_q, l1_q, l2_q;
	logic signed [36:0] h1_q, h2_q;
	logic [31:0] r1_q, r2_q;
	logic sat_q;

	logic signed [35:0] a1, a2, cx, sx;
	logic signed [37:0] t1, t2;
	logic signed [69:0] rnd, f1, f2, g1, g2;
	logic o1, o2;

	always_comb begin
		cx = 36'(c_q);
		sx = 36'(s_q);
		a1 = (sp_q[0] ? cx : 36'sd0) + (sq_q[0] ? sx : 36'sd0);
		a2 = (sq_q[0] ? cx : 36'sd0) - (sp_q[0] ? sx : 36'sd0);
		if (cnt_q == CW'(31)) begin
			a1 = -a1;
			a2 = -a2;
		end
		t1 = 38'(h1_q) + 38'(a1);
		t2 = 38'(h2_q) + 38'(a2);
		rnd = r30_q ? (70'sd1 <<< 29) : (70'sd1 <<< 15);
		f1 = $signed({h1_q[36], h1_q, l1_q}) + rnd;
		f2 = $signed({h2_q[36], h2_q, l2_q}) + rnd;
		g1 = r30_q ? (f1 >>> 30) : (f1 >>> 16);
		g2 = r30_q ? (f2 >>> 30) : (f2 >>> 16);
		o1 = !((&g1[69:31]) || !(|g1[69:31]));
		o2 = !((&g2[69:31]) || !(|g2[69:31]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			done_q <= fin_q;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(31)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			c_q <= mul_c;
			s_q <= mul_s;
			sp_q <= word_p;
			sq_q <= word_q;
			h1_q <= '0;
			h2_q <= '0;
			l1_q <= '0;
			l2_q <= '0;
			r30_q <= ctl.round30;
		end else if (busy_q) begin
			h1_q <= t1[37:1];
			h2_q <= t2[37:1];
			l1_q <= {t1[0], l1_q[31:1]};
			l2_q <= {t2[0], l2_q[31:1]};
			sp_q <= {1'b0, sp_q[31:1]};
			sq_q <= {1'b0, sq_q[31:1]};
		end
		if (fin_q) begin
			r1_q <= o1 ? (g1[69] ? 32'h8000_0000 : 32'h7fff_ffff) : g1[31:0];
			r2_q <= o2 ? (g2[69] ? 32'h8000_0000 : 32'h7fff_ffff) : g2[31:0];
			sat_q <= o1 | o2;
		end
	end

	assign res.done = done_q;
	assign res.sat = sat_q;
	assign res.r1 = r1_q;
	assign res.r2 = r2_q;
endmodule
`default_nettype wire
